// ===== design/stepper_tone_generator_limit_reverse_assert.svh =====
// ----------------------------------------------------------------------------
// stepper_tone_generator_limit_reverse_assert.svh
// assertion macros for the stepper tone generator, clocked on aclk and
// disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef STEPPER_TONE_GENERATOR_LIMIT_REVERSE_ASSERT_SVH
`define STEPPER_TONE_GENERATOR_LIMIT_REVERSE_ASSERT_SVH

// same-cycle implication
`define STGL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("stgl assertion failed");

// next-cycle implication
`define STGL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("stgl assertion failed");

`endif

// ===== design/stgl_pkg.sv =====
// ----------------------------------------------------------------------------
// stgl_pkg
// shared types, constants and the note period table of the stepper tone
// generator
// ----------------------------------------------------------------------------
`default_nettype none

package stgl_pkg;

    localparam int NOTE_COUNT  = 128;
    localparam int TIME_WIDTH  = 32;
    localparam int CNT_W       = $clog2(TIME_WIDTH);
    localparam int NOTE_W      = $clog2(NOTE_COUNT);
    localparam int PERIOD_W    = 17;
    localparam int HALF_W      = 16;
    localparam int CHECK_W     = 20;
    localparam int HOLDOFF_W   = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_ADDR_W  = 1;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 8;

    localparam logic [CHECK_W-1:0]   CHECK_RESET   = 20'd10000;
    localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 24'd500000;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT_CHECK_PERIOD = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_REVERSAL_HOLDOFF   = 1'd1;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_APPLY,
        ST_OUT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic div_step;
        logic apply;
        logic load_out;
    } stgl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic period_zero;
        logic div_last;
    } stgl_sts_t;

    // step period in microseconds per midi note, truncated 1e6 / note frequency
    localparam logic [PERIOD_W-1:0] PERIOD_ROM [NOTE_COUNT] = '{
        17'd122312, 17'd115447, 17'd108967, 17'd102851, 17'd97079, 17'd91630,
        17'd86487, 17'd81633, 17'd77051, 17'd72727, 17'd68645, 17'd64792,
        17'd61156, 17'd57723, 17'd54483, 17'd51425, 17'd48539, 17'd45815,
        17'd43243, 17'd40816, 17'd38525, 17'd36363, 17'd34322, 17'd32396,
        17'd30578, 17'd28861, 17'd27241, 17'd25712, 17'd24269, 17'd22907,
        17'd21621, 17'd20408, 17'd19262, 17'd18181, 17'd17161, 17'd16198,
        17'd15289, 17'd14430, 17'd13620, 17'd12856, 17'd12134, 17'd11453,
        17'd10810, 17'd10204, 17'd9631, 17'd9090, 17'd8580, 17'd8099,
        17'd7644, 17'd7215, 17'd6810, 17'd6428, 17'd6067, 17'd5726,
        17'd5405, 17'd5102, 17'd4815, 17'd4545, 17'd4290, 17'd4049,
        17'd3822, 17'd3607, 17'd3405, 17'd3214, 17'd3033, 17'd2863,
        17'd2702, 17'd2551, 17'd2407, 17'd2272, 17'd2145, 17'd2024,
        17'd1911, 17'd1803, 17'd1702, 17'd1607, 17'd1516, 17'd1431,
        17'd1351, 17'd1275, 17'd1203, 17'd1136, 17'd1072, 17'd1012,
        17'd955, 17'd901, 17'd851, 17'd803, 17'd758, 17'd715,
        17'd675, 17'd637, 17'd601, 17'd568, 17'd536, 17'd506,
        17'd477, 17'd450, 17'd425, 17'd401, 17'd379, 17'd357,
        17'd337, 17'd318, 17'd300, 17'd284, 17'd268, 17'd253,
        17'd238, 17'd225, 17'd212, 17'd200, 17'd189, 17'd178,
        17'd168, 17'd159, 17'd150, 17'd142, 17'd134, 17'd126,
        17'd119, 17'd112, 17'd106, 17'd100, 17'd94, 17'd89,
        17'd84, 17'd79
    };

endpackage

`default_nettype wire

// ===== design/stgl_ctrl.sv =====
// ----------------------------------------------------------------------------
// stgl_ctrl
// sequencer: accepts a transaction, runs the remainder loop for ticks while a
// note plays, applies the update and hands the result to the output register
// ----------------------------------------------------------------------------
`default_nettype none

module stgl_ctrl
    import stgl_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [1:0] s_op,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output stgl_cmd_t       cmd,
    input  wire stgl_sts_t  sts
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    // state and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    if (s_op == OP_TICK && !sts.period_zero) begin
                        state_next = ST_CALC;
                    end else begin
                        state_next = ST_APPLY;
                    end
                end
            end
            ST_CALC: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_valid_next = cmd.load_out | (m_valid_reg & ~m_tready);
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

// ===== design/stgl_dp.sv =====
// ----------------------------------------------------------------------------
// stgl_dp
// datapath: configuration registers, motion state, a two-lane bit-serial
// remainder unit and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module stgl_dp
    import stgl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [1:0]            s_op,
    input  wire logic [TIME_WIDTH-1:0] s_time,
    input  wire logic [NOTE_W-1:0]     s_note,
    input  wire logic                  s_limit,
    input  wire stgl_cmd_t             cmd,
    output stgl_sts_t                  sts,
    output logic [2:0]                 out_bits
);

    // configuration
    logic [CHECK_W-1:0]    check_cfg_reg;
    logic [HOLDOFF_W-1:0]  holdoff_cfg_reg;

    // latched transaction
    logic [1:0]            op_reg;
    logic [TIME_WIDTH-1:0] time_reg;
    logic [NOTE_W-1:0]     note_reg;
    logic                  limit_reg;

    // motion state
    logic [PERIOD_W-1:0]   period_reg;
    logic [HALF_W-1:0]     half_reg;
    logic                  step_reg;
    logic                  dir_reg;
    logic                  phase_reg;
    logic [TIME_WIDTH-1:0] holdoff_reg;
    logic                  enabled_reg;

    // remainder unit
    logic [CNT_W-1:0]      cnt_reg;
    logic [CHECK_W-1:0]    rem_p_reg, rem_p_next;
    logic [CHECK_W-1:0]    rem_c_reg, rem_c_next;
    logic [CHECK_W-1:0]    div_p, div_c;
    logic [CHECK_W:0]      trial_p, trial_c;
    logic                  time_bit;

    logic [2:0]            out_reg;

    // tick decisions
    logic                  first_half;
    logic                  step_new;
    logic                  reverse;
    logic [PERIOD_W-1:0]   rom_period;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_cfg_reg   <= CHECK_RESET;
            holdoff_cfg_reg <= HOLDOFF_RESET;
        end else if (cfg_we) begin
            if (cfg_addr == REG_LIMIT_CHECK_PERIOD) begin
                check_cfg_reg <= cfg_wdata[CHECK_W-1:0];
            end
            if (cfg_addr == REG_REVERSAL_HOLDOFF) begin
                holdoff_cfg_reg <= cfg_wdata[HOLDOFF_W-1:0];
            end
        end
    end

    // divisors: a zero check period counts as one
    assign div_p    = {{(CHECK_W-PERIOD_W){1'b0}}, period_reg};
    assign div_c    = (check_cfg_reg == '0) ? CHECK_W'(1) : check_cfg_reg;
    assign time_bit = time_reg[cnt_reg];

    // one restoring step per lane, msb of time first
    always_comb begin
        trial_p = {rem_p_reg, time_bit};
        trial_c = {rem_c_reg, time_bit};
        if (trial_p >= {1'b0, div_p}) begin
            rem_p_next = CHECK_W'(trial_p - {1'b0, div_p});
        end else begin
            rem_p_next = trial_p[CHECK_W-1:0];
        end
        if (trial_c >= {1'b0, div_c}) begin
            rem_c_next = CHECK_W'(trial_c - {1'b0, div_c});
        end else begin
            rem_c_next = trial_c[CHECK_W-1:0];
        end
    end

    // latch transaction and run the remainder loop
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg    <= s_op;
            time_reg  <= s_time;
            note_reg  <= s_note;
            limit_reg <= s_limit;
            cnt_reg   <= CNT_W'(TIME_WIDTH - 1);
            rem_p_reg <= '0;
            rem_c_reg <= '0;
        end else if (cmd.div_step) begin
            cnt_reg   <= cnt_reg - 1'b1;
            rem_p_reg <= rem_p_next;
            rem_c_reg <= rem_c_next;
        end
    end

    assign sts.div_last    = (cnt_reg == '0);
    assign sts.period_zero = (period_reg == '0);

    // tick outcome from the finished remainders
    assign rom_period = PERIOD_ROM[note_reg];
    assign first_half = rem_c_reg <= (div_c >> 1);
    assign step_new   = rem_p_reg <= {{(CHECK_W-HALF_W){1'b0}}, half_reg};
    assign reverse    = first_half && !phase_reg && (time_reg > holdoff_reg) && limit_reg;

    // motion state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= '0;
            half_reg    <= '0;
            step_reg    <= 1'b0;
            dir_reg     <= 1'b0;
            phase_reg   <= 1'b0;
            holdoff_reg <= '0;
            enabled_reg <= 1'b0;
        end else if (cmd.apply) begin
            case (op_reg)
                OP_TICK: begin
                    if (period_reg != '0) begin
                        step_reg  <= step_new;
                        phase_reg <= first_half;
                        if (reverse) begin
                            dir_reg     <= ~dir_reg;
                            holdoff_reg <= time_reg
                                + {{(TIME_WIDTH-HOLDOFF_W){1'b0}}, holdoff_cfg_reg};
                        end
                    end
                end
                OP_NOTE_ON: begin
                    enabled_reg <= 1'b1;
                    period_reg  <= rom_period;
                    half_reg    <= rom_period[PERIOD_W-1:1];
                    step_reg    <= 1'b0;
                    phase_reg   <= 1'b0;
                    holdoff_reg <= '0;
                end
                OP_NOTE_OFF: begin
                    enabled_reg <= 1'b0;
                    period_reg  <= '0;
                    half_reg    <= '0;
                    step_reg    <= 1'b0;
                    phase_reg   <= 1'b0;
                    holdoff_reg <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // output register: enable, direction, step from high to low
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg <= {enabled_reg, dir_reg, step_reg};
        end
    end

    assign out_bits = out_reg;

endmodule

`default_nettype wire

// ===== design/stepper_tone_generator_limit_reverse.sv =====
// ----------------------------------------------------------------------------
// stepper_tone_generator_limit_reverse
// stepper driven as a tone source with direction reversal at a limit switch
// ----------------------------------------------------------------------------
// Each input transaction (tick, note on, note off, or an unused code that
// changes nothing) produces one result with the step, direction and enable
// levels after the update. A tick while a note plays passes the accept
// state, the remainder loop, in which a bit-serial remainder unit forms
// time mod period and time mod check period side by side, one time bit per
// cycle, then the update state and the output load. All other transactions
// skip the remainder loop. A new transaction is accepted once the previous
// result has moved into the output register, even if it is still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_tone_generator_limit_reverse
    import stgl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,  // time_us[31:0], note[38:32], limit_hit[39]
    input  wire logic [1:0]            s_tuser,  // operation[1:0]
    // result channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata   // step_level[0], direction[1], enable[2], zero
);

    stgl_cmd_t  cmd;
    stgl_sts_t  sts;
    logic [2:0] out_bits;

    // sequencer
    stgl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // datapath
    stgl_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_op      (s_tuser),
        .s_time    (s_tdata[TIME_WIDTH-1:0]),
        .s_note    (s_tdata[TIME_WIDTH+NOTE_W-1:TIME_WIDTH]),
        .s_limit   (s_tdata[TIME_WIDTH+NOTE_W]),
        .cmd       (cmd),
        .sts       (sts),
        .out_bits  (out_bits)
    );

    assign m_tdata = {{(OUT_DATA_W-3){1'b0}}, out_bits};

    // checks
    `include "stepper_tone_generator_limit_reverse_assert.svh"

    // the block is busy right after taking a transaction
    `STGL_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // the step pin never stands high while the driver is off
    `STGL_ASSERT_IMPL(a_step_needs_enable, m_tvalid, !(m_tdata[0] && !m_tdata[2]))
    // a new result only appears after a transaction was in work
    `STGL_ASSERT_IMPL(a_result_after_work, $rose(m_tvalid), $past(!s_tready))

endmodule

`default_nettype wire

// ===== tb/sv/stgl_checker.sv =====
// ----------------------------------------------------------------------------
// stgl_checker
// watches the stepper tone generator channels, predicts every result from
// its own copy of the motion state and compares each output transaction
// ----------------------------------------------------------------------------
`default_nettype none

module stgl_checker
    import stgl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,  // time_us[31:0], note[38:32], limit_hit[39]
    input  wire logic [1:0]            s_tuser,  // operation[1:0]
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,  // step_level[0], direction[1], enable[2], zero
    output int                         fail_count,
    output int                         pending,
    output int                         results_seen,
    output int                         reversals
);
    timeunit 1ns;
    timeprecision 1ps;

    // pin levels in the order of the result bits
    typedef struct packed {
        logic enable;
        logic direction;
        logic step_level;
    } pins_t;

    // configuration copy
    logic [CHECK_W-1:0]    check_period_us;
    logic [HOLDOFF_W-1:0]  holdoff_us;

    // motion state copy
    logic [PERIOD_W-1:0]   period_us;
    logic [HALF_W-1:0]     half_us;
    logic                  step_q;
    logic                  dir_q;
    logic                  sample_phase;
    logic                  enabled_q;
    logic [TIME_WIDTH-1:0] holdoff_until;

    pins_t expected_pins_q[$];

    task automatic clear_motion();
        period_us     = '0;
        half_us       = '0;
        step_q        = 1'b0;
        sample_phase  = 1'b0;
        holdoff_until = '0;
    endtask

    // advance the motion state by one transaction and give the pin levels
    task automatic advance_motor(input logic [1:0] op, input logic [TIME_WIDTH-1:0] t,
                                 input logic [NOTE_W-1:0] note, input logic pressed,
                                 output pins_t pins);
        logic [TIME_WIDTH-1:0] span;
        logic                  first_half;
        case (op)
            OP_TICK: begin
                if (period_us != '0) begin
                    step_q = ((t % period_us) <= half_us);
                    // a zero check period acts as one
                    span = TIME_WIDTH'(check_period_us);
                    if (span == '0)
                        span = TIME_WIDTH'(1);
                    first_half = ((t % span) <= (span >> 1));
                    if (first_half && !sample_phase && pressed && (t > holdoff_until)) begin
                        dir_q         = ~dir_q;
                        holdoff_until = t + holdoff_us;
                        reversals++;
                    end
                    sample_phase = first_half;
                end
            end
            OP_NOTE_ON: begin
                clear_motion();
                enabled_q = 1'b1;
                period_us = PERIOD_ROM[note];
                half_us   = period_us[PERIOD_W-1:1];
            end
            OP_NOTE_OFF: begin
                clear_motion();
                enabled_q = 1'b0;
            end
            default: ;  // unused operation code leaves everything as it is
        endcase
        pins.step_level = step_q;
        pins.direction  = dir_q;
        pins.enable     = enabled_q;
    endtask

    task automatic flag(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t ns: %s", $time, what);
    endtask

    // configuration writes, input transactions, then output transactions
    always @(posedge aclk) begin : monitor
        pins_t want;
        pins_t got;
        if (!aresetn) begin
            check_period_us = CHECK_RESET;
            holdoff_us      = HOLDOFF_RESET;
            clear_motion();
            dir_q     = 1'b0;
            enabled_q = 1'b0;
            expected_pins_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_addr == REG_LIMIT_CHECK_PERIOD)
                    check_period_us = cfg_wdata[CHECK_W-1:0];
                else if (cfg_addr == REG_REVERSAL_HOLDOFF)
                    holdoff_us = cfg_wdata[HOLDOFF_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                advance_motor(s_tuser, s_tdata[TIME_WIDTH-1:0],
                              s_tdata[TIME_WIDTH +: NOTE_W], s_tdata[TIME_WIDTH+NOTE_W], want);
                expected_pins_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                got = m_tdata[2:0];
                if (expected_pins_q.size() == 0) begin
                    flag($sformatf("result %0d with nothing expected: step %0b dir %0b en %0b",
                                   results_seen, got.step_level, got.direction, got.enable));
                end else begin
                    want = expected_pins_q.pop_front();
                    if (got.step_level !== want.step_level)
                        flag($sformatf("result %0d step_level expected %0b got %0b",
                                       results_seen, want.step_level, got.step_level));
                    if (got.direction !== want.direction)
                        flag($sformatf("result %0d direction expected %0b got %0b",
                                       results_seen, want.direction, got.direction));
                    if (got.enable !== want.enable)
                        flag($sformatf("result %0d enable expected %0b got %0b",
                                       results_seen, want.enable, got.enable));
                end
            end
        end
        pending = expected_pins_q.size();
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// stimulus for the stepper tone generator: directed note and tick cases, then
// phases of random tone sequences under different limit settings and flow
// control, with the verdict taken from the checker
// ----------------------------------------------------------------------------
`default_nettype none

module tb
    import stgl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // operation code outside the defined set, must be ignored
    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam int PHASES           = 8;
    localparam int ITEMS_PER_PHASE  = 160;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;  // time_us[31:0], note[38:32], limit_hit[39]
    logic [1:0]            s_tuser   = '0;  // operation[1:0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // step_level[0], direction[1], enable[2], zero

    int fail_count;
    int pending;
    int results_seen;
    int reversals;

    int unsigned           send_idle_pct = 0;
    int unsigned           rx_stall_pct  = 0;
    int unsigned           items_sent    = 0;
    logic [CHECK_W-1:0]    check_now     = CHECK_RESET;
    logic [TIME_WIDTH-1:0] now_us        = '0;

    logic [CHECK_W-1:0]    check_set   [PHASES];
    logic [HOLDOFF_W-1:0]  holdoff_set [PHASES];

    stepper_tone_generator_limit_reverse uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    stgl_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .reversals    (reversals)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= rx_stall_pct);

    // one input transaction, with random idle cycles ahead of it
    task automatic send_item(input logic [1:0] op, input logic [TIME_WIDTH-1:0] t,
                             input logic [NOTE_W-1:0] note, input logic pressed);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pressed, note, t};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
    endtask

    // mostly time-ordered ticks walking through the sample phases,
    // with note changes, stray operations and random-time ticks mixed in
    task automatic random_item();
        int unsigned           r;
        int unsigned           span;
        logic [TIME_WIDTH-1:0] step;
        logic [NOTE_W-1:0]     note;
        logic                  pressed;
        r       = $urandom_range(99);
        span    = (check_now == '0) ? 1 : 32'(check_now);
        note    = NOTE_W'($urandom_range(NOTE_COUNT-1));
        pressed = 1'($urandom_range(1));
        if (r < 5) begin
            send_item(OP_NOTE_ON, $urandom(), note, pressed);
        end else if (r < 7) begin
            send_item(OP_NOTE_OFF, $urandom(), note, pressed);
        end else if (r < 9) begin
            send_item(OP_IGNORED, $urandom(), note, pressed);
        end else if (r < 17) begin
            send_item(OP_TICK, $urandom(), note, pressed);
        end else begin
            r = $urandom_range(9);
            if (r < 6)
                step = $urandom_range(span / 3 + 1, 1);
            else if (r < 8)
                step = $urandom_range(4, 1);
            else
                step = $urandom_range(4 * span, 1);
            now_us += step;
            send_item(OP_TICK, now_us, note, pressed);
        end
    endtask

    initial begin
        // limit settings per phase, extremes first
        check_set[0] = 20'd2;       holdoff_set[0] = 24'd0;
        check_set[1] = 20'd0;       holdoff_set[1] = 24'd0;
        check_set[2] = 20'd1;       holdoff_set[2] = 24'hFFFFFF;
        check_set[3] = 20'hFFFFF;   holdoff_set[3] = 24'd10000000;
        check_set[4] = 20'd1000000; holdoff_set[4] = 24'd0;
        check_set[5] = CHECK_W'($urandom_range(64, 2));
        holdoff_set[5] = HOLDOFF_W'($urandom_range(200));
        check_set[6] = CHECK_W'($urandom_range(5000, 2));
        holdoff_set[6] = HOLDOFF_W'($urandom_range(20000));
        check_set[7] = CHECK_RESET; holdoff_set[7] = HOLDOFF_RESET;

        repeat (9) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // directed cases at reset settings: check period 10000, holdoff 500000
        send_item(OP_TICK, 32'd0, 7'd0, 1'b1);           // tick while silent
        send_item(OP_IGNORED, 32'd0, 7'd0, 1'b1);
        send_item(OP_NOTE_OFF, 32'd0, 7'd0, 1'b0);
        send_item(OP_NOTE_ON, 32'd0, 7'd0, 1'b0);        // longest period
        send_item(OP_TICK, 32'd0, 7'd0, 1'b1);           // time not past holdoff of zero
        send_item(OP_TICK, 32'd6000, 7'd0, 1'b1);        // second half of the check period
        send_item(OP_TICK, 32'd10001, 7'd0, 1'b1);       // reversal
        send_item(OP_TICK, 32'd15000, 7'd0, 1'b1);
        send_item(OP_TICK, 32'd20000, 7'd0, 1'b1);       // inside holdoff, switch ignored
        send_item(OP_TICK, 32'd25001, 7'd0, 1'b0);
        send_item(OP_TICK, 32'd600000, 7'd0, 1'b1);      // holdoff expired, reversal
        send_item(OP_IGNORED, 32'hFFFFFFFF, 7'h7F, 1'b1); // ignored while playing
        send_item(OP_NOTE_ON, 32'd0, 7'd127, 1'b0);      // shortest period
        send_item(OP_TICK, 32'd39, 7'd0, 1'b0);          // mod period equals half period
        send_item(OP_TICK, 32'd40, 7'd0, 1'b0);          // one past half period
        send_item(OP_TICK, 32'd5000, 7'd0, 1'b1);        // last time of the first half
        send_item(OP_TICK, 32'd5001, 7'd0, 1'b1);        // first time of the second half
        send_item(OP_TICK, 32'hFFFFFFFF, 7'd0, 1'b1);
        send_item(OP_NOTE_ON, 32'hAAAAAAAA, 7'h55, 1'b1);
        send_item(OP_TICK, 32'hAAAAAAAA, 7'h2A, 1'b1);
        send_item(OP_TICK, 32'h55555555, 7'h55, 1'b0);
        send_item(OP_NOTE_ON, 32'h80000000, 7'h2A, 1'b0);
        send_item(OP_TICK, 32'h80000000, 7'd0, 1'b1);
        send_item(OP_NOTE_OFF, 32'd0, 7'd0, 1'b0);
        send_item(OP_TICK, 32'd5, 7'd0, 1'b1);           // tick after note off

        // random phases: new limit settings and flow control each time
        for (int phase = 0; phase < PHASES; phase++) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            wait (pending == 0);
            write_reg(REG_LIMIT_CHECK_PERIOD, CFG_DATA_W'(check_set[phase]));
            write_reg(REG_REVERSAL_HOLDOFF, holdoff_set[phase]);
            @(negedge aclk) cfg_we <= 1'b0;
            check_now = check_set[phase];
            case (phase % 4)
                0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin send_idle_pct = 79; rx_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rx_stall_pct = 79; end
                default: begin send_idle_pct = 32; rx_stall_pct = 32; end
            endcase
            // one phase starts just below the time wrap
            now_us = (phase == 2) ? 32'hFFFFFF80 : $urandom();
            send_item(OP_NOTE_ON, now_us, NOTE_W'($urandom_range(NOTE_COUNT-1)), 1'b0);
            repeat (ITEMS_PER_PHASE - 1) random_item();
        end

        // drain and let the block settle
        @(negedge aclk) s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (40) @(posedge aclk);

        $display("covered %0d transactions over %0d limit and flow-control phases",
                 items_sent, PHASES);
        $display("checked %0d results, %0d direction reversals predicted",
                 results_seen, reversals);
        if (fail_count == 0 && pending == 0)
            $display("stepper_tone_generator_limit_reverse: match");
        else
            $display("stepper_tone_generator_limit_reverse: mismatch");
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("stepper_tone_generator_limit_reverse: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/stgl_pkg.sv
design/stgl_ctrl.sv
design/stgl_dp.sv
design/stepper_tone_generator_limit_reverse.sv
tb/sv/stgl_checker.sv
tb/sv/tb.sv
